// File: src/cdws_pkg.sv
package cdws_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_DUMP       = 3'd4;
   localparam logic [2:0] CMD_SORT       = 3'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [2:0] OP_HOLD = 3'd0;
   localparam logic [2:0] OP_SHR  = 3'd1;
   localparam logic [2:0] OP_SHL  = 3'd2;
   localparam logic [2:0] OP_LOAD = 3'd3;
   localparam logic [2:0] OP_ROT  = 3'd4;
   localparam logic [2:0] OP_SORT = 3'd5;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] entry_value;
      logic               last;
      logic [CNT_W-1:0]   entry_count;
   } rsp_type;

   typedef struct packed {
      logic [2:0]       op;
      logic [CNT_W-1:0] count;
      logic             phase;
   } cell_ctl_type;

endpackage

// File: src/cdws_cell.sv
module cdws_cell (
   input  logic                      clock,
   input  cdws_pkg::cell_ctl_type    ctl,
   input  logic [cdws_pkg::IDX_W-1:0] index,
   input  logic signed [31:0]        left_val,
   input  logic signed [31:0]        right_val,
   input  logic signed [31:0]        head_val,
   input  logic signed [31:0]        push_val,
   output logic signed [31:0]        value
);
   import cdws_pkg::*;

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic [CNT_W-1:0]   idx_ext;
   logic               is_left;
   logic               is_right;

   assign idx_ext  = CNT_W'(index);
   assign is_left  = (index[0] == ctl.phase) && ((idx_ext + CNT_W'(1)) < ctl.count);
   assign is_right = (index != '0) && (index[0] != ctl.phase) && (idx_ext < ctl.count);

   always_comb begin
      value_in = value_ff;
      unique case (ctl.op)
         OP_SHR: value_in = left_val;
         OP_SHL: value_in = right_val;
         OP_LOAD: begin
            if (idx_ext == ctl.count) value_in = push_val;
         end
         OP_ROT: begin
            if (idx_ext == ctl.count - CNT_W'(1)) value_in = head_val;
            else value_in = right_val;
         end
         OP_SORT: begin
            if (is_left && (right_val > value_ff)) value_in = right_val;
            else if (is_right && (value_ff > left_val)) value_in = left_val;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: src/circular_deque_with_sort.sv
// Push, pop and unused commands: result registered at accept, one item per cycle while the response slot is free.
// Dump: one result per entry while the cell row rotates once; an empty deque gets one EMPTY result.
// Sort: result registered at accept, then (with more than one entry) count odd-even exchange phases
// in the cell row before the next item is taken.
// Reset: synchronous, clears occupancy and control; entry cells hold no reset value.
module circular_deque_with_sort (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdws_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdws_pkg::rsp_type rsp_data
);
   import cdws_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DUMP = 2'd1;
   localparam logic [1:0] ST_SORT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   cell_ctl_type       ctl;
   logic signed [31:0] cell_val [DEPTH];
   logic               slot_free;
   logic               accept;
   logic               rsp_load;
   logic               dump_last;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [31:0] left_val;
         logic signed [31:0] right_val;
         if (g == 0) begin : g_first
            assign left_val = req_data.value;
         end else begin : g_mid_l
            assign left_val = cell_val[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_val = '0;
         end else begin : g_mid_r
            assign right_val = cell_val[g+1];
         end
         cdws_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .index     (IDX_W'(g)),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (cell_val[0]),
            .push_val  (req_data.value),
            .value     (cell_val[g])
         );
      end
   endgenerate

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign dump_last = (step_ff + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      step_in     = step_ff;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      ctl.op      = OP_HOLD;
      ctl.count   = count_ff;
      ctl.phase   = step_ff[0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load                = 1'b1;
               rsp_data_in.status      = STATUS_OK;
               rsp_data_in.entry_value = '0;
               rsp_data_in.last        = 1'b1;
               unique case (req_data.cmd)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        ctl.op   = (req_data.cmd == CMD_PUSH_FRONT) ? OP_SHR : OP_LOAD;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        ctl.op   = (req_data.cmd == CMD_POP_FRONT) ? OP_SHL : OP_HOLD;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        rsp_load = 1'b0;
                        state_in = ST_DUMP;
                        step_in  = '0;
                     end
                  end
                  CMD_SORT: begin
                     if (count_ff > CNT_W'(1)) begin
                        state_in = ST_SORT;
                        step_in  = '0;
                     end
                  end
                  default: ;
               endcase
               rsp_data_in.entry_count = count_in;
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               rsp_load                = 1'b1;
               rsp_data_in.status      = STATUS_OK;
               rsp_data_in.entry_value = cell_val[0];
               rsp_data_in.last        = dump_last;
               rsp_data_in.entry_count = count_ff;
               ctl.op                  = OP_ROT;
               step_in                 = step_ff + CNT_W'(1);
               if (dump_last) state_in = ST_IDLE;
            end
         end
         ST_SORT: begin
            ctl.op  = OP_SORT;
            step_in = step_ff + CNT_W'(1);
            if (dump_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
